// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled while reset is asserted.
`define CHK_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/srlk_pkg.sv =====
`timescale 1ns / 1ps
package srlk_pkg;
  localparam int MaxKeys   = 16;
  localparam int MaxJoints = 8;
  localparam int KeyW      = $clog2(MaxKeys);
  localparam int JntW      = $clog2(MaxJoints);
  localparam int Turn      = 92160;

  // angle wrap: bias is a multiple of Turn above 2^31, Turn = 45 * 2048,
  // reciprocal is ceil(2^28 / 45)
  localparam logic [32:0] WrapBias  = 33'd2147512320;
  localparam logic [22:0] WrapRecip = 23'd5965233;
  localparam logic [5:0]  TurnHi    = 6'd45;

  localparam logic [2:0] CfgSpeedGain  = 3'd0;
  localparam logic [2:0] CfgDeadband   = 3'd1;
  localparam logic [2:0] CfgMaxStep    = 3'd2;
  localparam logic [2:0] CfgKeyCount   = 3'd3;
  localparam logic [2:0] CfgJointCount = 3'd4;

  typedef struct packed {
    logic               mode;
    logic [3:0]         key_index;
    logic [2:0]         joint_index;
    logic [16:0]        key_angle;
    logic signed [15:0] joint_value;
    logic               enabled;
    logic               hold;
    logic               fwd_cmd;
    logic signed [31:0] cmd_angle;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         joint_index_out;
    logic signed [15:0] joint_position;
    logic signed [31:0] wheel_angle;
    logic [31:0]        drive_count;
    logic               last;
  } out_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_UPD, ST_APPLY, ST_WRAP, ST_SCAN, ST_SCANW, ST_DIFF,
    ST_JRD, ST_JWT, ST_MULJ, ST_DIV, ST_OUT
  } state_t;
endpackage

// ===== design/srlk_if.sv =====
`timescale 1ns / 1ps
interface srlk_in_if;
  import srlk_pkg::*;
  logic    valid;
  logic    ready;
  in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srlk_out_if;
  import srlk_pkg::*;
  logic     valid;
  logic     ready;
  out_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/steering_rate_limit_keyframe_interp_top.sv =====
`timescale 1ns / 1ps
// Steering rate limiter with key-frame joint interpolation. A load request
// (mode 0) writes one key angle and one joint value in the cycle it is taken.
// A tick request (mode 1) that is enabled and not on hold runs the rate
// limit, applies the new wheel angle and wraps it into one turn with a
// reciprocal multiply, scans the key table one row a cycle through its
// synchronous memory, then for each joint reads both frames, multiplies and
// divides. One request at a time. A result waits in the output register
// until taken, which stalls the next joint.
module steering_rate_limit_keyframe_interp_top (
  input  logic        clk,
  input  logic        rst_n,
  srlk_in_if.sink     in_ch,
  srlk_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import srlk_pkg::*;

  logic [16:0]        key_mem [MaxKeys];
  logic [15:0]        frm_mem [MaxKeys*MaxJoints];
  logic [16:0]        key_rd_r;
  logic [15:0]        frm_rd_r;
  logic [KeyW-1:0]    key_ra;
  logic [KeyW+JntW-1:0] frm_ra;

  logic [15:0] gain_r, dead_r, mstep_r;
  logic [4:0]  kcnt_r;
  logic [3:0]  jcnt_r;

  state_t st_r, st_nxt;
  in_req_t req_r;
  logic signed [31:0] held_r;
  logic [31:0] dcnt_r;
  logic signed [33:0] err_r;
  logic [32:0] mag_r;
  logic [16:0] frac_r;
  logic [16:0] step_r;
  logic [16:0] ang_r;
  logic [32:0] rem_r;
  logic [16:0] wq_r;
  logic [5:0]  cnt_r;
  logic [4:0]  kidx_r;
  logic [KeyW-1:0] pr_r, nx_r, mx_r, mn_r;
  logic [16:0] prk_r, nxk_r, mxk_r, mnk_r;
  logic        prv_r, nxv_r;
  logic [16:0] pd_r, nd_r;
  logic [17:0] den_r;
  logic [JntW:0] j_r;
  logic        ph_r;
  logic signed [15:0] p_r;
  logic [33:0] num_r;
  logic        neg_r;
  logic [33:0] quo_r;
  logic [18:0] drem_r;
  logic        ov_r;
  out_req_t    ob_r;

  logic [4:0] kc;
  logic [3:0] jc;
  assign kc = (kcnt_r == 5'd0) ? 5'd1 : ((kcnt_r > 5'(MaxKeys)) ? 5'(MaxKeys) : kcnt_r);
  assign jc = (jcnt_r == 4'd0) ? 4'd1 : ((jcnt_r > 4'(MaxJoints)) ? 4'(MaxJoints) : jcnt_r);

  assign in_ch.ready = (st_r == ST_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data = ob_r;

  logic acc;
  assign acc = in_ch.valid && in_ch.ready;

  // memories
  always_comb begin
    key_ra = kidx_r[KeyW-1:0];
    frm_ra = {(ph_r ? nx_r : pr_r), j_r[JntW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (acc && !in_ch.data.mode) begin
      key_mem[in_ch.data.key_index[KeyW-1:0]] <= in_ch.data.key_angle;
      frm_mem[{in_ch.data.key_index[KeyW-1:0], in_ch.data.joint_index[JntW-1:0]}]
        <= in_ch.data.joint_value;
    end
    key_rd_r <= key_mem[key_ra];
    frm_rd_r <= frm_mem[frm_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= 16'd256; dead_r <= 16'd256; mstep_r <= 16'd512;
      kcnt_r <= 5'd1; jcnt_r <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgSpeedGain:  gain_r <= cfg_data;
        CfgDeadband:   dead_r <= cfg_data;
        CfgMaxStep:    mstep_r <= cfg_data;
        CfgKeyCount:   kcnt_r <= cfg_data[4:0];
        CfgJointCount: jcnt_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (acc && in_ch.data.mode && in_ch.data.enabled && !in_ch.data.hold)
                  st_nxt = ST_MUL1;
      ST_MUL1:  st_nxt = ST_MUL2;
      ST_MUL2:  st_nxt = ST_UPD;
      ST_UPD:   st_nxt = ST_APPLY;
      ST_APPLY: st_nxt = ST_WRAP;
      ST_WRAP:  st_nxt = ST_SCAN;
      ST_SCAN:  st_nxt = ST_SCANW;
      ST_SCANW: if (kidx_r == kc) st_nxt = ST_DIFF;
      ST_DIFF:  st_nxt = ST_JRD;
      ST_JRD:   st_nxt = ST_JWT;
      ST_JWT:   if (ph_r) st_nxt = ST_MULJ; else st_nxt = ST_JRD;
      ST_MULJ:  st_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == 6'd0) st_nxt = ST_OUT;
      ST_OUT:   if (!ov_r) st_nxt = (j_r + 1'b1 == (JntW+1)'(jc)) ? ST_IDLE : ST_JRD;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  logic signed [33:0] nh;
  logic signed [31:0] held_sat;
  logic [48:0] fprod;
  logic [44:0] wmul;
  logic [21:0] wr;
  logic signed [18:0] pdiff, ndiff;
  logic signed [34:0] prod;
  logic [19:0] dsub;
  logic [15:0] pos;
  always_comb begin
    nh = 34'(held_r);
    if (err_r > $signed({18'd0, dead_r})) nh = 34'(held_r) + $signed({1'b0, step_r});
    else if (err_r < -$signed({18'd0, dead_r})) nh = 34'(held_r) - $signed({1'b0, step_r});
    if (nh > 34'sh7fffffff) held_sat = 32'sh7fffffff;
    else if (nh < -34'sh80000000) held_sat = 32'sh80000000;
    else held_sat = nh[31:0];
    fprod = {16'd0, mag_r} * {33'd0, gain_r};
    wmul = {23'd0, rem_r[32:11]} * {22'd0, WrapRecip};
    wr = rem_r[32:11] - ({5'd0, wq_r} * {16'd0, TurnHi});
    pdiff = $signed({2'b0, ang_r}) - $signed({2'b0, prk_r});
    ndiff = $signed({2'b0, nxk_r}) - $signed({2'b0, ang_r});
    prod = $signed({1'b0, nd_r}) * p_r + $signed({1'b0, pd_r}) * $signed(frm_rd_r);
    dsub = {drem_r, quo_r[33]} - {2'b0, den_r};
    if (den_r == 18'd0) pos = p_r;
    else if (!neg_r && quo_r > 34'd32767) pos = 16'sh7fff;
    else if (neg_r && quo_r > 34'd32768) pos = 16'sh8000;
    else if (neg_r) pos = 16'(-quo_r[15:0]);
    else pos = quo_r[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; held_r <= '0; dcnt_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      case (st_r)
        ST_IDLE: if (acc) begin
          req_r <= in_ch.data;
          err_r <= 34'(in_ch.data.cmd_angle) - 34'(held_r);
        end
        ST_MUL1: begin
          mag_r <= err_r[33] ? 33'(-err_r) : err_r[32:0];
        end
        ST_MUL2: begin
          frac_r <= (fprod > 49'd65536) ? 17'd65536 : fprod[16:0];
        end
        ST_UPD: begin
          step_r <= 17'(({16'd0, mstep_r} * {15'd0, frac_r}) >> 16);
        end
        ST_APPLY: begin
          held_r <= held_sat;
          if (req_r.fwd_cmd) dcnt_r <= dcnt_r + 32'd1;
          rem_r <= {held_sat[31], held_sat} + WrapBias;
          kidx_r <= '0;
        end
        ST_WRAP: begin
          wq_r <= wmul[44:28];
        end
        ST_SCAN: begin
          ang_r <= {wr[5:0], rem_r[10:0]};
          kidx_r <= kidx_r + 5'd1; prv_r <= 1'b0; nxv_r <= 1'b0;
        end
        ST_SCANW: begin
          if (kidx_r != kc) kidx_r <= kidx_r + 5'd1;
          if (key_rd_r <= ang_r && (!prv_r || key_rd_r > prk_r)) begin
            prv_r <= 1'b1; pr_r <= KeyW'(kidx_r - 5'd1); prk_r <= key_rd_r;
          end
          if (key_rd_r > ang_r && (!nxv_r || key_rd_r < nxk_r)) begin
            nxv_r <= 1'b1; nx_r <= KeyW'(kidx_r - 5'd1); nxk_r <= key_rd_r;
          end
          if (kidx_r == 5'd1 || key_rd_r > mxk_r) begin
            mx_r <= KeyW'(kidx_r - 5'd1); mxk_r <= key_rd_r;
          end
          if (kidx_r == 5'd1 || key_rd_r < mnk_r) begin
            mn_r <= KeyW'(kidx_r - 5'd1); mnk_r <= key_rd_r;
          end
        end
        ST_DIFF: begin
          if (!prv_r) begin pr_r <= mx_r; prk_r <= mxk_r; end
          if (!nxv_r) begin nx_r <= mn_r; nxk_r <= mnk_r; end
          j_r <= '0; ph_r <= 1'b0;
        end
        ST_JRD: begin
          // keys may lie beyond one turn
          if (!pdiff[18]) pd_r <= pdiff[16:0];
          else if (pdiff >= -19'(Turn)) pd_r <= 17'(pdiff + 19'(Turn));
          else pd_r <= 17'(pdiff + 19'(2 * Turn));
          if (ndiff[18]) nd_r <= 17'(ndiff + 19'(Turn));
          else if (ndiff >= 19'(Turn)) nd_r <= 17'(ndiff - 19'(Turn));
          else nd_r <= ndiff[16:0];
        end
        ST_JWT: begin
          den_r <= {1'b0, pd_r} + {1'b0, nd_r};
          if (!ph_r) begin p_r <= frm_rd_r; ph_r <= 1'b1; end
          else begin
            neg_r <= prod[34];
            num_r <= prod[34] ? 34'(-prod) : prod[33:0];
            ph_r <= 1'b0;
          end
        end
        ST_MULJ: begin
          quo_r <= num_r + 34'(den_r >> 1); drem_r <= '0; cnt_r <= 6'd34;
        end
        ST_DIV: begin
          if (cnt_r != 6'd0) begin
            if (!dsub[19]) begin drem_r <= dsub[18:0]; quo_r <= {quo_r[32:0], 1'b1}; end
            else begin drem_r <= {drem_r[17:0], quo_r[33]}; quo_r <= {quo_r[32:0], 1'b0}; end
            cnt_r <= cnt_r - 6'd1;
          end
        end
        ST_OUT: if (!ov_r) begin
          ov_r <= 1'b1;
          ob_r.joint_index_out <= 3'(j_r);
          ob_r.joint_position <= pos;
          ob_r.wheel_angle <= held_r;
          ob_r.drive_count <= dcnt_r;
          ob_r.last <= (j_r + 1'b1 == (JntW+1)'(jc));
          j_r <= j_r + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== design/srlk_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srlk_chk (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input srlk_pkg::out_req_t out_data
);
  `CHK_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  `CHK_NXT(a_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data), "result changed")
  `CHK_IMP(a_busy, clk, rst_n, out_valid && !out_data.last, !in_ready, "request taken mid tick")
endmodule

bind steering_rate_limit_keyframe_interp_top srlk_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
